[sv/pftr_pkg.sv]
// ----------------------------------------------------------------------------
// pftr_pkg
// Shared types and constants for the camera pixel to RGB888 converter.
// ----------------------------------------------------------------------------
package pftr_pkg;

  // source pixel formats
  typedef enum logic [2:0] {
    FMT_YUYV   = 3'd0,
    FMT_UYVY   = 3'd1,
    FMT_YVYU   = 3'd2,
    FMT_NV12   = 3'd3,
    FMT_NV21   = 3'd4,
    FMT_RGB565 = 3'd5
  } pix_fmt_e;

  // configuration register indexes
  localparam logic REG_PIXEL_FORMAT = 1'b0;
  localparam logic REG_SWAP_CHROMA  = 1'b1;

  // bt.601 full-range coefficients, 18-bit signed fixed point with 16 fraction bits (Q2.16)
  localparam logic signed [17:0] COEF_RV = 18'sd91881;
  localparam logic signed [17:0] COEF_GU = 18'sd22554;
  localparam logic signed [17:0] COEF_GV = 18'sd46802;
  localparam logic signed [17:0] COEF_BU = 18'sd116130;

  localparam int unsigned FRAC_BITS = 16;

  // one input pixel request
  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic       odd_column;
  } pix_in_t;

  // one converted pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

endpackage

[sv/pftr_conv.sv]
// ----------------------------------------------------------------------------
// pftr_conv
// Combinational format decode and BT.601 conversion (or RGB565 expansion) of one pixel.
// ----------------------------------------------------------------------------
module pftr_conv (
  input  pftr_pkg::pix_in_t  pix_i,
  input  logic [2:0]         fmt_i,
  input  logic               swap_i,
  output pftr_pkg::rgb_out_t rgb_o
);
  import pftr_pkg::*;

  logic [7:0]        y_byte;
  logic [7:0]        u_byte;
  logic [7:0]        v_byte;
  logic signed [7:0] u_s;
  logic signed [7:0] v_s;
  logic signed [25:0] prod_rv;
  logic signed [25:0] prod_gu;
  logic signed [25:0] prod_gv;
  logic signed [25:0] prod_bu;
  logic signed [10:0] y_s;
  logic signed [10:0] r_sum;
  logic signed [10:0] g_sum;
  logic signed [10:0] b_sum;
  logic [4:0]        r5;
  logic [5:0]        g6;
  logic [4:0]        b5;

  // pick luma and chroma bytes for the yuv formats
  always_comb begin
    y_byte = pix_i.byte_a;
    u_byte = pix_i.byte_b;
    v_byte = pix_i.byte_c;
    case (fmt_i)
      FMT_YUYV: begin
        y_byte = pix_i.odd_column ? pix_i.byte_c : pix_i.byte_a;
        u_byte = pix_i.byte_b;
        v_byte = pix_i.byte_d;
      end
      FMT_UYVY: begin
        y_byte = pix_i.odd_column ? pix_i.byte_d : pix_i.byte_b;
        u_byte = pix_i.byte_a;
        v_byte = pix_i.byte_c;
      end
      FMT_YVYU: begin
        y_byte = pix_i.odd_column ? pix_i.byte_c : pix_i.byte_a;
        u_byte = pix_i.byte_d;
        v_byte = pix_i.byte_b;
      end
      FMT_NV12: begin
        u_byte = pix_i.byte_b;
        v_byte = pix_i.byte_c;
      end
      FMT_NV21: begin
        u_byte = pix_i.byte_c;
        v_byte = pix_i.byte_b;
      end
      default: begin
        y_byte = pix_i.byte_a;
      end
    endcase
  end

  // remove chroma offset (flip msb) and apply optional swap
  assign u_s = swap_i ? $signed(v_byte ^ 8'h80) : $signed(u_byte ^ 8'h80);
  assign v_s = swap_i ? $signed(u_byte ^ 8'h80) : $signed(v_byte ^ 8'h80);

  // constant coefficient products
  assign prod_rv = COEF_RV * v_s;
  assign prod_gu = COEF_GU * u_s;
  assign prod_gv = COEF_GV * v_s;
  assign prod_bu = COEF_BU * u_s;

  // floor by arithmetic shift: upper bits of each product
  assign y_s   = $signed({3'b000, y_byte});
  assign r_sum = y_s + 11'($signed(prod_rv[25:FRAC_BITS]));
  assign g_sum = y_s - 11'($signed(prod_gu[25:FRAC_BITS]))
                     - 11'($signed(prod_gv[25:FRAC_BITS]));
  assign b_sum = y_s + 11'($signed(prod_bu[25:FRAC_BITS]));

  // rgb565 fields
  assign r5 = pix_i.byte_b[7:3];
  assign g6 = {pix_i.byte_b[2:0], pix_i.byte_a[7:5]};
  assign b5 = pix_i.byte_a[4:0];

  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // output select
  always_comb begin
    case (fmt_i)
      FMT_YUYV, FMT_UYVY, FMT_YVYU, FMT_NV12, FMT_NV21: begin
        rgb_o.red   = sat8(r_sum);
        rgb_o.green = sat8(g_sum);
        rgb_o.blue  = sat8(b_sum);
      end
      FMT_RGB565: begin
        rgb_o.red   = {r5, r5[4:2]};
        rgb_o.green = {g6, g6[5:4]};
        rgb_o.blue  = {b5, b5[4:2]};
      end
      default: begin
        rgb_o = '0;
      end
    endcase
  end

endmodule

[sv/pixel_format_to_rgb888_top.sv]
// ----------------------------------------------------------------------------
// pixel_format_to_rgb888_top
// Camera pixel to RGB888 converter with valid/ready streams and APB config.
// ----------------------------------------------------------------------------
// path: an accepted request is held in the input register, then converted into the
// result register
// throughput: one pixel per cycle while out_ready_i is high; conversion is one pass
// of constant multiplies between the input register and the result register
// reset: rst_ni async active low clears both stage valids and the config
// registers (format YUYV, no chroma swap)
module pixel_format_to_rgb888_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pftr_pkg::pix_in_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pftr_pkg::rgb_out_t out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pftr_pkg::*;

  logic [2:0] fmt_q;
  logic       swap_q;
  logic       cfg_wr;
  logic       s1_valid_q;
  pix_in_t    s1_pix_q;
  logic       s1_ready;
  logic       out_valid_q;
  rgb_out_t   out_rsp_q;
  rgb_out_t   conv_rgb;

  // config register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_YUYV;
      swap_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PIXEL_FORMAT: fmt_q  <= pwdata[2:0];
        REG_SWAP_CHROMA:  swap_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    case (paddr[2])
      REG_PIXEL_FORMAT: prdata = {29'd0, fmt_q};
      REG_SWAP_CHROMA:  prdata = {31'd0, swap_q};
      default:          prdata = 32'd0;
    endcase
  end

  // pipeline handshake: each stage advances when the next one frees up
  assign s1_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_pix_q <= in_req_i;
    end
  end

  // conversion
  pftr_conv u_conv (
    .pix_i  (s1_pix_q),
    .fmt_i  (fmt_q),
    .swap_i (swap_q),
    .rgb_o  (conv_rgb)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ready) begin
      out_rsp_q <= conv_rgb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // no stall at the input while the output side is taking results
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled although output is ready");

  // an accepted request lands in the input register
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted request lost from input register");

  // a new result only ever comes from a filled input register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(s1_valid_q))
    else $error("result appeared without a pending request");

endmodule
